// ===== sv/idsc_pkg.sv =====
// Shared types and constants for the incremental distinct substring counter.
// No dependencies; imported by every module of the block.
package idsc_pkg;

  // Default number of characters the text store holds
  localparam int unsigned DEPTH_DEFAULT = 1024;

  // Field widths fixed by the stream format
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned TOTAL_W = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Control bits that travel with a character along the cell chain
  typedef struct packed {
    logic live;  // slot carries an accepted word
    logic drop;  // store was full at entry; touch no state
  } tok_ctl_t;

endpackage

// ===== sv/incremental_distinct_substring_count.sv =====
// Incremental distinct substring counter, top level.
// Input stream s_*: one word per character. s_tdata[7:0] is the character,
// s_tdata[18:8] its 1-based position in the current word (0 for a
// separator), upper bits zero. Output stream m_*: one word per input word,
// in order. m_tdata[10:0] new distinct substrings ending at the character,
// m_tdata[30:11] saturating running total, m_tuser[0] set when the store
// was full and the character was dropped (new count 0, total unchanged).
// Each character travels down a chain of DEPTH cells, one cell per cycle
// unless stalled; every cell below the fill point compares it with its
// stored character, updates its common-suffix length and folds that into
// a running maximum carried along. m_tvalid rises once the word has passed
// the DEPTH cell registers and then the result register, the first of which
// loads at the accepting edge. The chain is fully pipelined, so one word
// is taken per cycle while the output is drained.
// A stall on m_tready freezes the whole chain and drops s_tready in the same
// cycle; the result register holds its word until taken.
// Reset clears the fill count, all suffix lengths, the total and the slot
// valid bits; stored characters are rewritten before they are compared.
module incremental_distinct_substring_count
  import idsc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned IW = $clog2(DEPTH + 1),
  localparam int unsigned LW = $clog2(DEPTH)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_in[7:0], word_position[18:8], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // new_count[10:0], total_count[30:11], zero fill
  output logic [0:0]  m_tuser    // overflow[0]
);

  localparam logic [IW-1:0] FULL_AT = IW'(DEPTH);

  logic               en;
  logic               full;
  logic [IW-1:0]      fill;
  logic               out_valid;
  logic [POS_W-1:0]   new_count;
  logic [TOTAL_W-1:0] total_count;
  logic               overflow;

  tok_ctl_t          ctl_c  [DEPTH+1];
  logic [CHAR_W-1:0] c_c    [DEPTH+1];
  logic [POS_W-1:0]  pos_c  [DEPTH+1];
  logic [IW-1:0]     idx_c  [DEPTH+1];
  logic [LW-1:0]     prev_c [DEPTH+1];
  logic [LW-1:0]     max_c  [DEPTH+1];

  // Move the whole chain whenever the result register can take a word
  assign en       = !out_valid || m_tready;
  assign s_tready = en;
  assign full     = fill == FULL_AT;

  // Count stored characters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (s_tvalid && en && !full) begin
      fill <= fill + 1'b1;
    end
  end

  // Feed the head of the chain
  always_comb begin
    ctl_c[0].live = s_tvalid;
    ctl_c[0].drop = full;
    c_c[0]        = s_tdata[CHAR_W-1:0];
    pos_c[0]      = s_tdata[CHAR_W+POS_W-1:CHAR_W];
    idx_c[0]      = fill;
    prev_c[0]     = '0;
    max_c[0]      = '0;
  end

  // Row of match cells
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    idsc_cell #(
      .DEPTH (DEPTH),
      .INDEX (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl_c[j]),
      .c_in     (c_c[j]),
      .pos_in   (pos_c[j]),
      .idx_in   (idx_c[j]),
      .prev_in  (prev_c[j]),
      .max_in   (max_c[j]),
      .ctl_out  (ctl_c[j+1]),
      .c_out    (c_c[j+1]),
      .pos_out  (pos_c[j+1]),
      .idx_out  (idx_c[j+1]),
      .prev_out (prev_c[j+1]),
      .max_out  (max_c[j+1])
    );
  end

  idsc_tally #(
    .DEPTH (DEPTH)
  ) u_tally (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ctl_in      (ctl_c[DEPTH]),
    .pos_in      (pos_c[DEPTH]),
    .best_in     (max_c[DEPTH]),
    .out_valid   (out_valid),
    .new_count   (new_count),
    .total_count (total_count),
    .overflow    (overflow)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, total_count, new_count};
  assign m_tuser  = overflow;

  // Fill count never passes the store size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_AT)
    else $error("fill count beyond store size");

  // A dropped character reports no new substrings
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[POS_W-1:0] == '0))
    else $error("dropped character with nonzero count");

  // Once full, the store stays full
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("store left full state without reset");

  // A stalled chain leaves the fill count alone
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fill))
    else $error("fill count moved during stall");

endmodule

// ===== sv/idsc_cell.sv =====
// One cell of the suffix-match chain: holds one stored character and its
// common-suffix length, and passes the traveling character on. Uses idsc_pkg.
module idsc_cell
  import idsc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned INDEX = 0,
  localparam int unsigned IW = $clog2(DEPTH + 1),
  localparam int unsigned LW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tok_ctl_t          ctl_in,
  input  logic [CHAR_W-1:0] c_in,
  input  logic [POS_W-1:0]  pos_in,
  input  logic [IW-1:0]     idx_in,
  input  logic [LW-1:0]     prev_in,
  input  logic [LW-1:0]     max_in,
  output tok_ctl_t          ctl_out,
  output logic [CHAR_W-1:0] c_out,
  output logic [POS_W-1:0]  pos_out,
  output logic [IW-1:0]     idx_out,
  output logic [LW-1:0]     prev_out,
  output logic [LW-1:0]     max_out
);

  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

  logic [CHAR_W-1:0] ch;
  logic [LW-1:0]     len;
  logic [LW-1:0]     len_next;
  logic [LW-1:0]     max_next;
  logic              act;
  logic              below;
  logic              at_end;

  // Work out this cell's new suffix length for the passing character
  always_comb begin
    act      = ctl_in.live && !ctl_in.drop;
    below    = MY_INDEX < idx_in;
    at_end   = MY_INDEX == idx_in;
    len_next = (ch == c_in) ? prev_in + 1'b1 : '0;
    max_next = (below && (len_next > max_in)) ? len_next : max_in;
  end

  // Update the cell state and the control bits of the outgoing slot
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
      if (act && below) begin
        len <= len_next;
      end
    end
  end

  // Hand the payload to the next cell; store the character at the fill point
  always_ff @(posedge clk) begin
    if (en) begin
      c_out    <= c_in;
      pos_out  <= pos_in;
      idx_out  <= idx_in;
      prev_out <= len;
      max_out  <= max_next;
      if (act && at_end) begin
        ch <= c_in;
      end
    end
  end

endmodule

// ===== sv/idsc_tally.sv =====
// Output stage: clamps the repeated-suffix length, forms the new count and
// keeps the saturating running total. Uses idsc_pkg.
module idsc_tally
  import idsc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned LW = $clog2(DEPTH),
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tok_ctl_t           ctl_in,
  input  logic [POS_W-1:0]   pos_in,
  input  logic [LW-1:0]      best_in,
  output logic               out_valid,
  output logic [POS_W-1:0]   new_count,
  output logic [TOTAL_W-1:0] total_count,
  output logic               overflow
);

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [CW-1:0]      best_w;
  logic [CW-1:0]      pos_w;
  logic [POS_W-1:0]   clamp;
  logic [POS_W-1:0]   fresh;
  logic [TOTAL_W:0]   sum;

  // Clamp to the word position, then add with saturation
  always_comb begin
    best_w     = CW'(best_in);
    pos_w      = CW'(pos_in);
    clamp      = (best_w > pos_w) ? pos_in : best_w[POS_W-1:0];
    fresh      = pos_in - clamp;
    sum        = {1'b0, total} + (TOTAL_W + 1)'(fresh);
    total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  // Advance valid and the running total
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      total     <= '0;
    end else if (en) begin
      out_valid <= ctl_in.live;
      if (ctl_in.live && !ctl_in.drop) begin
        total <= total_next;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (en) begin
      new_count   <= ctl_in.drop ? '0 : fresh;
      total_count <= ctl_in.drop ? total : total_next;
      overflow    <= ctl_in.drop;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Testbench for incremental_distinct_substring_count: streams characters with word
// positions through the block and checks every count word against a built-in predictor.
// Depends on idsc_pkg and the RTL of the block only.
module testbench
  import idsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned TOP_POS     = (1 << POS_W) - 1;
  localparam int unsigned TAIL_START  = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CHAR_W-1:0] SEP_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] LETTER_A = 8'h61;

  typedef struct {
    logic [POS_W-1:0]   fresh;
    logic [TOTAL_W-1:0] total;
    logic               dropped;
  } count_word_t;

  // Tracks the text and the running count, and holds the counts still owed by the block
  class substring_tally;
    bit [CHAR_W-1:0] text[DEPTH];
    int unsigned     match_len[DEPTH];
    int unsigned     fill;
    int unsigned     total;
    int unsigned     errors;
    count_word_t     owed_q[$];

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Append one character and queue the count it must produce
    function void note_char(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] pos);
      int unsigned best;
      int unsigned run;
      count_word_t w;
      best = 0;
      if (fill >= DEPTH) begin
        w.fresh   = '0;
        w.total   = total[TOTAL_W-1:0];
        w.dropped = 1'b1;
        owed_q.insert(owed_q.size(), w);
        return;
      end
      // walk downward so each entry sees its neighbor's previous length
      for (int unsigned j = fill; j > 1; j--) begin
        run = (text[j-1] == c) ? match_len[j-2] + 1 : 0;
        match_len[j-1] = run;
        if (run > best) best = run;
      end
      if (fill >= 1) begin
        run = (text[0] == c) ? 1 : 0;
        match_len[0] = run;
        if (run > best) best = run;
      end
      text[fill] = c;
      fill++;
      if (best > pos) best = pos;
      total += pos - best;
      if (total > TOTAL_MAX) total = TOTAL_MAX;
      w.fresh   = POS_W'(pos - best);
      w.total   = total[TOTAL_W-1:0];
      w.dropped = 1'b0;
      owed_q.insert(owed_q.size(), w);
    endfunction

    // Compare one output word with the oldest owed count
    task check_count(input logic [31:0] data, input logic [0:0] user);
      count_word_t w;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%h user=%b", data, user));
        return;
      end
      w = owed_q.pop_front();
      if (data[POS_W-1:0] !== w.fresh)
        report_mismatch($sformatf("new_count %0d, want %0d", data[POS_W-1:0], w.fresh));
      if (data[POS_W +: TOTAL_W] !== w.total)
        report_mismatch($sformatf("total_count %0d, want %0d",
                                  data[POS_W +: TOTAL_W], w.total));
      if (user[0] !== w.dropped)
        report_mismatch($sformatf("overflow %b, want %b", user[0], w.dropped));
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  substring_tally tally = new;
  int unsigned    send_idle_pct = 21;
  int unsigned    recv_idle_pct = 84;
  int unsigned    accepted = 0;
  int unsigned    cycle_count = 0;

  incremental_distinct_substring_count #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Take count words, stalling at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tally.check_count(m_tdata, m_tuser);
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one character word and hold it until taken
  task automatic send_word(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, pos, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tally.note_char(c, pos);
    accepted++;
  endtask

  // Mostly words over small alphabets, often repeated; some noise; a stretch of
  // out-of-range positions late in the fill to drive the total into saturation
  task automatic run_random(input int unsigned n);
    int unsigned       sent;
    int unsigned       len;
    int unsigned       alpha;
    int unsigned       word_len;
    logic [CHAR_W-1:0] word_buf[64];
    sent = 0;
    word_len = 0;
    while (sent < n) begin
      if (accepted >= TAIL_START && accepted < DEPTH && $urandom_range(99) < 90) begin
        send_word(CHAR_W'(LETTER_A + $urandom_range(3)), POS_W'($urandom_range(1900, TOP_POS)));
        sent++;
      end else if ($urandom_range(99) < 10) begin
        send_word(CHAR_W'($urandom_range(255)), POS_W'($urandom_range(TOP_POS)));
        sent++;
      end else begin
        if (word_len == 0 || $urandom_range(99) >= 30) begin
          len = ($urandom_range(99) < 5) ? $urandom_range(13, 64) : $urandom_range(1, 12);
          alpha = $urandom_range(1, 4);
          for (int unsigned i = 0; i < len; i++)
            word_buf[i] = CHAR_W'(LETTER_A + $urandom_range(alpha - 1));
          word_len = len;
        end
        for (int unsigned i = 0; i < word_len; i++) send_word(word_buf[i], POS_W'(i + 1));
        send_word(SEP_CHAR, '0);
        sent += word_len + 1;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, separators, a repeated word longer than its position
    send_word(8'h00, POS_W'(TOP_POS));
    send_word(8'hFF, '0);
    send_word(8'h00, 11'd1);
    send_word(8'h00, 11'd1024);
    send_word(SEP_CHAR, '0);
    send_word(LETTER_A, 11'd1);
    send_word(LETTER_A + 8'd1, 11'd2);
    send_word(LETTER_A, 11'd3);
    send_word(LETTER_A + 8'd1, 11'd4);
    send_word(SEP_CHAR, '0);
    send_word(LETTER_A, 11'd1);
    send_word(LETTER_A + 8'd1, 11'd2);
    send_word(LETTER_A, 11'd3);
    send_word(LETTER_A + 8'd1, 11'd4);
    send_word(SEP_CHAR, '0);
    send_word(8'h55, 11'h555);
    send_word(8'hAA, 11'h2AA);
    send_word(8'h7F, 11'h400);

    run_random(510);
    send_idle_pct = 84;
    recv_idle_pct = 21;
    run_random(510);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(510);
    s_tvalid <= 1'b0;

    // Drain, then watch for stray words
    while (tally.pending() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (tally.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/idsc_pkg.sv
sv/idsc_cell.sv
sv/idsc_tally.sv
sv/incremental_distinct_substring_count.sv
test/testbench.sv
